>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// concurrent assertion helpers used by upd_out_buffer
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> hdl/upd_pkg.sv
// ----------------------------------------------------------------------------
// upd_pkg
// shared constants, types and escape lookup for the url percent decoder
// ----------------------------------------------------------------------------
package upd_pkg;

   localparam int BYTE_W  = 8;
   localparam int SLOTS   = 3;
   localparam int COUNT_W = 2;

   localparam logic [BYTE_W-1:0] CH_PLUS    = 8'h2B;
   localparam logic [BYTE_W-1:0] CH_PERCENT = 8'h25;
   localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
   localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
   localparam logic [BYTE_W-1:0] CH_NINE    = 8'h39;
   localparam logic [BYTE_W-1:0] CH_TWO     = 8'h32;
   localparam logic [BYTE_W-1:0] CH_THREE   = 8'h33;
   localparam logic [BYTE_W-1:0] CH_FOUR    = 8'h34;
   localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'h41;
   localparam logic [BYTE_W-1:0] CH_UPPER_F = 8'h46;

   localparam logic [COUNT_W-1:0] HELD_NONE    = 2'd0;
   localparam logic [COUNT_W-1:0] HELD_PERCENT = 2'd1;
   localparam logic [COUNT_W-1:0] HELD_DIGIT   = 2'd2;

   typedef struct packed {
      logic [COUNT_W-1:0]           count;
      logic [SLOTS-1:0][BYTE_W-1:0] bytes;
      logic [SLOTS-1:0]             lasts;
   } dec_result_type;

   typedef struct packed {
      logic                ok;
      logic [BYTE_W-1:0]   value;
   } lookup_type;

   function automatic lookup_type escape_lookup(input logic [BYTE_W-1:0] d,
                                                input logic [BYTE_W-1:0] c);
      lookup_type r;
      logic [3:0] lo;
      logic       hex;
      r.ok    = 1'b0;
      r.value = '0;
      lo      = 4'd0;
      hex     = 1'b0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         lo  = c[3:0];
         hex = 1'b1;
      end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
         lo  = 4'(c[3:0] + 4'd9);
         hex = 1'b1;
      end
      if (hex) begin
         if (d == CH_TWO) begin
            r.ok    = !(lo == 4'h0 || lo == 4'hD || lo == 4'hE);
            r.value = {4'h2, lo};
         end else if (d == CH_THREE) begin
            r.ok    = (lo >= 4'hA);
            r.value = {4'h3, lo};
         end else if (d == CH_FOUR) begin
            r.ok    = (lo == 4'h0);
            r.value = 8'h40;
         end
      end
      return r;
   endfunction

endpackage

>>> hdl/upd_decode.sv
// ----------------------------------------------------------------------------
// upd_decode
// escape decoding of one registered byte and the held escape state
// ----------------------------------------------------------------------------
module upd_decode (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         fire,
   input  logic [upd_pkg::BYTE_W-1:0]   in_byte,
   input  logic                         in_last,
   output upd_pkg::dec_result_type      result
);
   import upd_pkg::*;

   logic [COUNT_W-1:0] held_count_ff, held_count_in;
   logic [BYTE_W-1:0]  held_digit_ff, held_digit_in;

   always_comb begin : decode
      logic [COUNT_W-1:0] n;
      logic [COUNT_W-1:0] cnt;
      logic [BYTE_W-1:0]  dig;
      logic               fresh;
      lookup_type         lk;
      n            = '0;
      cnt          = HELD_NONE;
      dig          = held_digit_ff;
      fresh        = 1'b0;
      result.bytes = '0;
      result.lasts = '0;
      lk           = escape_lookup(held_digit_ff, in_byte);
      case (held_count_ff)
         HELD_PERCENT: begin
            if (in_byte == CH_TWO || in_byte == CH_THREE || in_byte == CH_FOUR) begin
               cnt = HELD_DIGIT;
               dig = in_byte;
            end else begin
               result.bytes[n] = CH_PERCENT;
               n = n + 2'd1;
               fresh = 1'b1;
            end
         end
         HELD_DIGIT: begin
            if (lk.ok) begin
               result.bytes[n] = lk.value;
               n = n + 2'd1;
            end else begin
               result.bytes[n] = CH_PERCENT;
               n = n + 2'd1;
               result.bytes[n] = held_digit_ff;
               n = n + 2'd1;
               fresh = 1'b1;
            end
         end
         default: begin
            fresh = 1'b1;
         end
      endcase
      if (fresh) begin
         if (in_byte == CH_PERCENT) begin
            cnt = HELD_PERCENT;
         end else begin
            result.bytes[n] = (in_byte == CH_PLUS) ? CH_SPACE : in_byte;
            n = n + 2'd1;
         end
      end
      if (in_last) begin
         if (cnt == HELD_PERCENT || cnt == HELD_DIGIT) begin
            result.bytes[n] = CH_PERCENT;
            n = n + 2'd1;
         end
         if (cnt == HELD_DIGIT) begin
            result.bytes[n] = dig;
            n = n + 2'd1;
         end
         cnt = HELD_NONE;
         dig = '0;
         result.lasts[n - 2'd1] = 1'b1;
      end
      result.count  = n;
      held_count_in = fire ? cnt : held_count_ff;
      held_digit_in = fire ? dig : held_digit_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff <= HELD_NONE;
         held_digit_ff <= '0;
      end else begin
         held_count_ff <= held_count_in;
         held_digit_ff <= held_digit_in;
      end
   end

endmodule

>>> hdl/upd_out_buffer.sv
// ----------------------------------------------------------------------------
// upd_out_buffer
// result register holding up to three decoded bytes, drained one per transfer
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module upd_out_buffer (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load,
   input  upd_pkg::dec_result_type      result,
   output logic                         can_load,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [upd_pkg::BYTE_W-1:0]   rsp_tdata,  // out_byte [7:0]
   output logic                         rsp_tlast   // out_last
);
   import upd_pkg::*;

   logic [SLOTS-1:0][BYTE_W-1:0] bytes_ff, bytes_in;
   logic [SLOTS-1:0]             lasts_ff, lasts_in;
   logic [COUNT_W-1:0]           left_ff, left_in;
   logic [COUNT_W-1:0]           rd_ff, rd_in;
   logic                         take;

   assign rsp_tvalid = (left_ff != '0);
   assign take       = rsp_tvalid && rsp_tready;
   assign can_load   = (left_ff == '0) || (left_ff == 2'd1 && rsp_tready);
   assign rsp_tdata  = bytes_ff[rd_ff];
   assign rsp_tlast  = lasts_ff[rd_ff];

   always_comb begin
      bytes_in = bytes_ff;
      lasts_in = lasts_ff;
      left_in  = left_ff;
      rd_in    = rd_ff;
      if (load) begin
         bytes_in = result.bytes;
         lasts_in = result.lasts;
         left_in  = result.count;
         rd_in    = '0;
      end else if (take) begin
         left_in = left_ff - 2'd1;
         rd_in   = rd_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
      lasts_ff <= lasts_in;
      if (reset) begin
         left_ff <= '0;
         rd_ff   <= '0;
      end else begin
         left_ff <= left_in;
         rd_ff   <= rd_in;
      end
   end

   `ASSERT_ALWAYS(a_slot_range, clock, reset, (3'(rd_ff) + 3'(left_ff)) <= 3'(SLOTS))
   `ASSERT_NEXT(a_drain_empty, clock, reset, take && left_ff == 2'd1 && !load, !rsp_tvalid)
   `ASSERT_ALWAYS(a_last_final, clock, reset, !(take && rsp_tlast) || left_ff == 2'd1)

endmodule

>>> hdl/url_percent_decoder_top.sv
// ----------------------------------------------------------------------------
// url_percent_decoder_top
// url percent decoder: one byte in, zero to three decoded bytes out
// path: a byte passes from the input register through the decoder into the
//   result register, from which its first result can transfer
// throughput: one byte per cycle while rsp_tready is high and each byte
//   yields at most one result; more results hold the input to the last transfer
// reset: synchronous, clears the held escape state and the result register
// ----------------------------------------------------------------------------
module url_percent_decoder_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [upd_pkg::BYTE_W-1:0]   req_tdata,  // in_byte [7:0]
   input  logic                         req_tlast,  // in_last
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [upd_pkg::BYTE_W-1:0]   rsp_tdata,  // out_byte [7:0]
   output logic                         rsp_tlast   // out_last
);
   import upd_pkg::*;

   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              last_ff, last_in;
   logic              can_load;
   logic              move;
   logic              accept;
   dec_result_type    result;

   assign move       = valid_ff && can_load;
   assign req_tready = !valid_ff || move;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      valid_in = accept ? 1'b1 : (move ? 1'b0 : valid_ff);
      byte_in  = accept ? req_tdata : byte_ff;
      last_in  = accept ? req_tlast : last_ff;
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   upd_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .fire    (move),
      .in_byte (byte_ff),
      .in_last (last_ff),
      .result  (result)
   );

   upd_out_buffer u_out_buffer (
      .clock      (clock),
      .reset      (reset),
      .load       (move),
      .result     (result),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
